### hdl/range_encoder_core_defines.svh
// Assertion macros shared by the range encoder checks
`ifndef RANGE_ENCODER_CORE_DEFINES_SVH
`define RANGE_ENCODER_CORE_DEFINES_SVH

// Consequent checked in the cycle after the antecedent
`define REC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("range encoder check failed");

// Consequent checked in the same cycle as the antecedent
`define REC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("range encoder check failed");

`endif

### hdl/rec_pkg.sv
package rec_pkg;

    // Fixed widths and sizes
    localparam int unsigned CNT_W       = 6;
    localparam int unsigned PLAN_DEPTH  = 4;
    localparam int unsigned PLAN_IDX_W  = 2;
    localparam int unsigned SHIFT_W     = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // Arithmetic constants
    localparam logic [31:0]        LEN_RENORM = 32'h00ffffff;
    localparam logic [31:0]        CUM_FULL   = 32'hffffffff;
    localparam logic [31:0]        BASE_RESET = 32'h00000000;
    localparam logic [31:0]        LEN_RESET  = 32'hffffffff;
    localparam logic [7:0]         BYTE_FF    = 8'hff;
    localparam logic [7:0]         BYTE_00    = 8'h00;
    localparam logic [SHIFT_W-1:0] MAX_SHIFTS = 2'd3;
    localparam logic               CMD_FLUSH  = 1'b1;

    typedef enum logic {
        OP_ENCODE,
        OP_FLUSH
    } t_op;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_MUL_HI,
        ENG_MUL_LO,
        ENG_UPDATE,
        ENG_RENORM,
        ENG_HANDOFF
    } t_eng_state;

    // Input transaction as seen on the ports
    typedef struct packed {
        logic        cmd;
        logic [31:0] sym_freq;
        logic [31:0] sym_cum_high;
    } t_enc_in;

    // Result transaction as seen on the ports
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       pending_overflow;
    } t_enc_out;

    // Classified work item between front and engine
    typedef struct packed {
        t_op         op;
        logic [31:0] cum_high;
        logic [31:0] cum_low;
    } t_work;

    // One lead byte followed by count copies of 0xff or 0x00
    typedef struct packed {
        logic [7:0]       lead;
        logic             fill_ff;
        logic [CNT_W-1:0] count;
    } t_burst;

    // All results of one item
    typedef struct packed {
        t_burst [PLAN_DEPTH-1:0] bursts;
        logic [PLAN_IDX_W:0]     n_bursts;
        logic                    ovf;
    } t_plan;

endpackage

### hdl/rec_front.sv
module rec_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  rec_pkg::t_enc_in i_item,
    output rec_pkg::t_work  o_work,
    output logic            o_work_valid,
    input  logic            i_work_take
);

    rec_pkg::t_work                  r_mem [rec_pkg::QUEUE_DEPTH];
    logic [rec_pkg::QPTR_W-1:0]      r_wr;
    logic [rec_pkg::QPTR_W-1:0]      r_rd;
    logic [rec_pkg::QCNT_W-1:0]      r_cnt;
    rec_pkg::t_work                  w_work;
    logic                            w_push;
    logic                            w_pop;

    // Classify the transaction and resolve the open upper bound
    always_comb begin
        w_work.op       = (i_item.cmd == rec_pkg::CMD_FLUSH) ? rec_pkg::OP_FLUSH
                                                             : rec_pkg::OP_ENCODE;
        w_work.cum_high = (i_item.sym_cum_high == 32'd0) ? rec_pkg::CUM_FULL
                                                         : i_item.sym_cum_high;
        w_work.cum_low  = w_work.cum_high - i_item.sym_freq;
    end

    assign full         = (r_cnt == rec_pkg::QCNT_W'(rec_pkg::QUEUE_DEPTH));
    assign w_push       = push && !full;
    assign w_pop        = i_work_take && (r_cnt != '0);
    assign o_work_valid = (r_cnt != '0);
    assign o_work       = r_mem[r_rd];

    // Store classified items
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_work;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hdl/rec_engine.sv
module rec_engine #(
    parameter int unsigned PENDING_MAX = 60
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rec_pkg::t_work i_work,
    input  logic           i_work_valid,
    output logic           o_work_take,
    output rec_pkg::t_plan o_plan,
    output logic           o_plan_valid,
    input  logic           i_plan_ready
);

    localparam logic [rec_pkg::CNT_W-1:0] PendMax = rec_pkg::CNT_W'(PENDING_MAX);

    rec_pkg::t_eng_state r_state, n_state;
    logic [31:0] r_base, n_base;
    logic [31:0] r_len, n_len;
    logic [7:0]  r_held, n_held;
    logic        r_held_valid, n_held_valid;
    logic [rec_pkg::CNT_W-1:0] r_pend, n_pend;
    logic [rec_pkg::SHIFT_W-1:0] r_shift, n_shift;
    logic [rec_pkg::PLAN_IDX_W:0] r_nb, n_nb;
    logic        r_ovf, n_ovf;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic [31:0] r_y, n_y;
    logic [31:0] r_x, n_x;
    rec_pkg::t_burst [rec_pkg::PLAN_DEPTH-1:0] r_bursts, n_bursts;

    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [32:0] w_sum;
    logic [7:0]  w_byte;
    logic [rec_pkg::PLAN_IDX_W-1:0] w_slot;

    // Shared multiplier: upper bound first, lower bound next
    assign w_mul_b = (r_state == rec_pkg::ENG_MUL_HI) ? r_hi : r_lo;
    assign w_prod  = {32'd0, r_len} * {32'd0, w_mul_b};
    assign w_sum   = {1'b0, r_base} + {1'b0, r_x};
    assign w_byte  = r_base[31:24];
    assign w_slot  = r_nb[rec_pkg::PLAN_IDX_W-1:0];

    assign o_plan.bursts   = r_bursts;
    assign o_plan.n_bursts = r_nb;
    assign o_plan.ovf      = r_ovf;

    // Next state, interval update and byte bookkeeping
    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_len        = r_len;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_pend       = r_pend;
        n_shift      = r_shift;
        n_nb         = r_nb;
        n_ovf        = r_ovf;
        n_hi         = r_hi;
        n_lo         = r_lo;
        n_y          = r_y;
        n_x          = r_x;
        n_bursts     = r_bursts;
        o_work_take  = 1'b0;
        o_plan_valid = 1'b0;
        case (r_state)
            rec_pkg::ENG_IDLE: begin
                if (i_work_valid) begin
                    o_work_take = 1'b1;
                    n_nb        = '0;
                    n_ovf       = 1'b0;
                    n_hi        = i_work.cum_high;
                    n_lo        = i_work.cum_low;
                    if (i_work.op == rec_pkg::OP_FLUSH) begin
                        // Release the held byte and its run of 0xff
                        if (r_held_valid) begin
                            n_bursts[0].lead    = r_held;
                            n_bursts[0].fill_ff = 1'b1;
                            n_bursts[0].count   = r_pend;
                            n_nb                = {{rec_pkg::PLAN_IDX_W{1'b0}}, 1'b1};
                        end
                        n_held_valid = 1'b0;
                        n_pend       = '0;
                        n_state      = rec_pkg::ENG_HANDOFF;
                    end else begin
                        n_state = rec_pkg::ENG_MUL_HI;
                    end
                end
            end
            rec_pkg::ENG_MUL_HI: begin
                n_y     = w_prod[63:32];
                n_state = rec_pkg::ENG_MUL_LO;
            end
            rec_pkg::ENG_MUL_LO: begin
                n_x     = w_prod[63:32];
                n_state = rec_pkg::ENG_UPDATE;
            end
            rec_pkg::ENG_UPDATE: begin
                n_base  = w_sum[31:0];
                n_len   = r_y - r_x;
                n_shift = '0;
                // Propagate a carry into the held bytes
                if (w_sum[32] && r_held_valid) begin
                    if (r_pend == '0) begin
                        n_held = r_held + 8'd1;
                    end else begin
                        n_bursts[w_slot].lead    = r_held + 8'd1;
                        n_bursts[w_slot].fill_ff = 1'b0;
                        n_bursts[w_slot].count   = r_pend - 1'b1;
                        n_nb                     = r_nb + 1'b1;
                        n_held                   = rec_pkg::BYTE_00;
                        n_pend                   = '0;
                    end
                end
                n_state = rec_pkg::ENG_RENORM;
            end
            rec_pkg::ENG_RENORM: begin
                if ((r_len < rec_pkg::LEN_RENORM) && (r_shift != rec_pkg::MAX_SHIFTS)) begin
                    // Shift out the top byte of the base
                    if (!r_held_valid) begin
                        n_held       = w_byte;
                        n_held_valid = 1'b1;
                        n_pend       = '0;
                    end else if ((w_byte == rec_pkg::BYTE_FF) && (r_pend < PendMax)) begin
                        n_pend = r_pend + 1'b1;
                    end else begin
                        if (w_byte == rec_pkg::BYTE_FF) begin
                            n_ovf = 1'b1;
                        end
                        n_bursts[w_slot].lead    = r_held;
                        n_bursts[w_slot].fill_ff = 1'b1;
                        n_bursts[w_slot].count   = r_pend;
                        n_nb                     = r_nb + 1'b1;
                        n_held                   = w_byte;
                        n_pend                   = '0;
                    end
                    n_base  = {r_base[23:0], 8'd0};
                    n_len   = {r_len[23:0], 8'd0};
                    n_shift = r_shift + 1'b1;
                end else begin
                    n_state = rec_pkg::ENG_HANDOFF;
                end
            end
            rec_pkg::ENG_HANDOFF: begin
                // Pass a finished plan with bursts to the emitter; an empty plan is dropped
                if (r_nb == '0) begin
                    n_state = rec_pkg::ENG_IDLE;
                end else if (i_plan_ready) begin
                    o_plan_valid = 1'b1;
                    n_state      = rec_pkg::ENG_IDLE;
                end
            end
            default: begin
                n_state = rec_pkg::ENG_IDLE;
            end
        endcase
    end

    // Control and interval state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rec_pkg::ENG_IDLE;
            r_base       <= rec_pkg::BASE_RESET;
            r_len        <= rec_pkg::LEN_RESET;
            r_held       <= rec_pkg::BYTE_00;
            r_held_valid <= 1'b0;
            r_pend       <= '0;
            r_shift      <= '0;
            r_nb         <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_base       <= n_base;
            r_len        <= n_len;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_pend       <= n_pend;
            r_shift      <= n_shift;
            r_nb         <= n_nb;
            r_ovf        <= n_ovf;
        end
    end

    // Operands, products and plan payload
    always_ff @(posedge i_clk) begin
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_y      <= n_y;
        r_x      <= n_x;
        r_bursts <= n_bursts;
    end

endmodule

### hdl/rec_emit.sv
module rec_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rec_pkg::t_plan    i_plan,
    input  logic              i_plan_valid,
    output logic              o_plan_ready,
    output rec_pkg::t_enc_out o_result,
    output logic              o_empty,
    input  logic              i_pop
);

    rec_pkg::t_plan    r_plan, n_plan;
    rec_pkg::t_enc_out r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic              r_busy, n_busy;
    logic              r_in_fill, n_in_fill;
    logic [rec_pkg::PLAN_IDX_W-1:0] r_idx, n_idx;
    logic [rec_pkg::CNT_W-1:0]      r_rem, n_rem;

    rec_pkg::t_burst w_burst;
    logic            w_advance;
    logic            w_last_burst;
    logic            w_burst_end;
    logic [7:0]      w_byte;

    assign w_burst      = r_plan.bursts[r_idx];
    assign w_advance    = r_busy && (!r_out_valid || i_pop);
    assign w_last_burst = (({1'b0, r_idx} + 1'b1) == r_plan.n_bursts);
    assign o_plan_ready = !r_busy;
    assign o_result     = r_out;
    assign o_empty      = !r_out_valid;

    // Pick the next byte of the current burst
    always_comb begin
        if (!r_in_fill) begin
            w_byte      = w_burst.lead;
            w_burst_end = (w_burst.count == '0);
        end else begin
            w_byte      = w_burst.fill_ff ? rec_pkg::BYTE_FF : rec_pkg::BYTE_00;
            w_burst_end = (r_rem == rec_pkg::CNT_W'(1));
        end
    end

    // Stream bytes into the output register
    always_comb begin
        n_plan      = r_plan;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_busy      = r_busy;
        n_in_fill   = r_in_fill;
        n_idx       = r_idx;
        n_rem       = r_rem;
        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end
        if (w_advance) begin
            n_out.out_byte         = w_byte;
            n_out.last             = w_last_burst && w_burst_end;
            n_out.pending_overflow = r_plan.ovf;
            n_out_valid            = 1'b1;
            if (w_burst_end) begin
                n_in_fill = 1'b0;
                n_idx     = r_idx + 1'b1;
                if (w_last_burst) begin
                    n_busy = 1'b0;
                end
            end else if (!r_in_fill) begin
                n_in_fill = 1'b1;
                n_rem     = w_burst.count;
            end else begin
                n_rem = r_rem - 1'b1;
            end
        end
        if (!r_busy && i_plan_valid) begin
            n_plan    = i_plan;
            n_busy    = 1'b1;
            n_idx     = '0;
            n_in_fill = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_in_fill   <= 1'b0;
            r_idx       <= '0;
            r_rem       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_busy      <= n_busy;
            r_in_fill   <= n_in_fill;
            r_idx       <= n_idx;
            r_rem       <= n_rem;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_plan <= n_plan;
        r_out  <= n_out;
    end

endmodule

### hdl/range_encoder_core.sv
// Encode item: the engine steps through queue pop, upper and lower multiply, update, 0-3 shifts
// plus a check, and handoff. Flush: queue pop, then handoff. The engine takes a new item only
// once back in idle; it waits in handoff while the emitter still streams the previous plan
// at one byte per cycle while results are popped.
// Reset is synchronous, active low: queue emptied, base 0, length 0xffffffff, nothing held.
module range_encoder_core #(
    parameter int unsigned PENDING_MAX = 60
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rec_pkg::t_enc_in  i_item,
    output logic              empty,
    input  logic              pop,
    output rec_pkg::t_enc_out o_result
);

    rec_pkg::t_work w_work;
    logic           w_work_valid;
    logic           w_work_take;
    rec_pkg::t_plan w_plan;
    logic           w_plan_valid;
    logic           w_plan_ready;

    // Accept and classify
    rec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_item       (i_item),
        .o_work       (w_work),
        .o_work_valid (w_work_valid),
        .i_work_take  (w_work_take)
    );

    // Interval arithmetic and carry resolution
    rec_engine #(
        .PENDING_MAX (PENDING_MAX)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (w_work),
        .i_work_valid (w_work_valid),
        .o_work_take  (w_work_take),
        .o_plan       (w_plan),
        .o_plan_valid (w_plan_valid),
        .i_plan_ready (w_plan_ready)
    );

    // Byte streaming
    rec_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan       (w_plan),
        .i_plan_valid (w_plan_valid),
        .o_plan_ready (w_plan_ready),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

### hdl/rec_checker.sv
`include "range_encoder_core_defines.svh"

module rec_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input rec_pkg::t_enc_out o_result
);

    logic w_mid_run;

    // A result taken that is not the last of its transaction
    assign w_mid_run = !empty && pop && !o_result.last;

    // Hold a stalled result
    `REC_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(o_result))

    // Results of one item follow without a gap and share the overflow flag
    `REC_ASSERT_NEXT(a_ovf_run, w_mid_run, !empty && $stable(o_result.pending_overflow))

    // Leave reset with no result pending and the input queue not full
    `REC_ASSERT_NOW(a_reset_state, $rose(i_rst_n), empty && !full)

    // The input queue fills only through an accepted transaction
    `REC_ASSERT_NOW(a_full_on_push, $rose(full), $past(push && !full))

endmodule

bind range_encoder_core rec_checker u_rec_checker (.*);

### dv/range_encoder_core_test.sv
`timescale 1ns / 100ps

module range_encoder_core_test;

    localparam int unsigned PEND_MAX     = 60;
    localparam int unsigned MAX_CODES    = 64;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS = 105;

    // Coder state kept alongside the block
    typedef struct {
        logic [31:0] base;
        logic [31:0] len;
        logic [7:0]  held;
        logic        held_ok;
        int unsigned pend;
    } t_coder;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push    = 1'b0;
    logic              pop     = 1'b0;
    rec_pkg::t_enc_in  i_item  = '0;
    logic              full;
    logic              empty;
    rec_pkg::t_enc_out o_result;

    t_coder            coder;
    logic [7:0]        item_raw[$];
    rec_pkg::t_enc_out item_codes[$];
    rec_pkg::t_enc_out coded_exp[$];
    logic              item_ovf;
    int                mismatches = 0;
    int                sink_hold  = 0;
    bit                no_gaps    = 1'b0;

    range_encoder_core #(
        .PENDING_MAX(PEND_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Give up after a generous bound
    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Coder prediction
    // ------------------------------------------------------------------

    function automatic void put_byte(input logic [7:0] b);
        if (item_raw.size() < MAX_CODES) begin
            item_raw.push_back(b);
        end
    endfunction

    // Release the held byte and its run of 0xff
    function automatic void release_held();
        if (!coder.held_ok) begin
            return;
        end
        put_byte(coder.held);
        for (int unsigned i = 0; i < coder.pend; i++) begin
            put_byte(rec_pkg::BYTE_FF);
        end
        coder.pend = 0;
    endfunction

    // Advance the coder by one transaction and build its coded bytes
    function automatic void code_item(input rec_pkg::t_enc_in it);
        logic [31:0]       cum;
        logic [31:0]       hi;
        logic [31:0]       lo;
        logic [31:0]       b0;
        logic [63:0]       prod;
        logic [7:0]        c;
        int                shifts;
        rec_pkg::t_enc_out r;
        item_raw.delete();
        item_codes.delete();
        item_ovf = 1'b0;
        if (it.cmd == rec_pkg::CMD_FLUSH) begin
            release_held();
            coder.held_ok = 1'b0;
            coder.pend    = 0;
        end else begin
            cum = (it.sym_cum_high == 32'h0) ? rec_pkg::CUM_FULL : it.sym_cum_high;
            prod = {32'h0, coder.len} * {32'h0, cum};
            hi = prod[63:32];
            prod = {32'h0, coder.len} * {32'h0, cum - it.sym_freq};
            lo = prod[63:32];
            b0 = coder.base;
            coder.base = b0 + lo;
            coder.len  = hi - lo;
            // Propagate a carry into the held byte and its run
            if (coder.base < b0 && coder.held_ok) begin
                if (coder.pend == 0) begin
                    coder.held = coder.held + 8'd1;
                end else begin
                    put_byte(coder.held + 8'd1);
                    for (int unsigned i = 1; i < coder.pend; i++) begin
                        put_byte(rec_pkg::BYTE_00);
                    end
                    coder.held = rec_pkg::BYTE_00;
                    coder.pend = 0;
                end
            end
            // Renormalise, at most three bytes
            shifts = 0;
            while (coder.len < rec_pkg::LEN_RENORM && shifts < 3) begin
                c = coder.base[31:24];
                if (!coder.held_ok) begin
                    coder.held    = c;
                    coder.held_ok = 1'b1;
                    coder.pend    = 0;
                end else if (c == rec_pkg::BYTE_FF) begin
                    if (coder.pend < PEND_MAX) begin
                        coder.pend++;
                    end else begin
                        item_ovf = 1'b1;
                        release_held();
                        coder.held = c;
                    end
                end else begin
                    release_held();
                    coder.held = c;
                end
                coder.base = coder.base << 8;
                coder.len  = coder.len << 8;
                shifts++;
            end
        end
        foreach (item_raw[k]) begin
            r.out_byte         = item_raw[k];
            r.last             = (k == item_raw.size() - 1);
            r.pending_overflow = item_ovf;
            item_codes.push_back(r);
        end
    endfunction

    // Look ahead: would this transaction collapse the interval to zero
    function automatic bit zeroes_length(input rec_pkg::t_enc_in it);
        t_coder saved;
        bit     z;
        saved = coder;
        code_item(it);
        z = (coder.len == 32'h0);
        coder = saved;
        return z;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic rec_pkg::t_enc_in flush_item();
        rec_pkg::t_enc_in it;
        it.cmd          = rec_pkg::OP_FLUSH;
        it.sym_freq     = $urandom;
        it.sym_cum_high = $urandom;
        return it;
    endfunction

    function automatic rec_pkg::t_enc_in random_encode();
        rec_pkg::t_enc_in it;
        it.cmd = rec_pkg::OP_ENCODE;
        do begin
            it.sym_freq = $urandom >> $urandom_range(0, 28);
            if (it.sym_freq < 32'h400) begin
                it.sym_freq = it.sym_freq | 32'h400;
            end
            it.sym_cum_high = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom;
        end while (zeroes_length(it));
        return it;
    endfunction

    // Aim the interval so that the next coded byte is b and the length
    // lands just under the renormalisation bound (one shift).  With the
    // base top byte at 0xff, any b below 0xff wraps the base: a carry.
    function automatic rec_pkg::t_enc_in next_byte_item(input logic [7:0] b);
        rec_pkg::t_enc_in it;
        logic [31:0]      target;
        logic [31:0]      delta;
        logic [31:0]      lt;
        logic [63:0]      span;
        logic [63:0]      q;
        logic [63:0]      p;
        target = {b, 8'hff, 16'($urandom_range(0, 16'hfeff))};
        lt     = 32'h0080_0000 + $urandom_range(0, 32'h007f_fff0);
        delta  = target - coder.base;
        if (delta >= coder.len) begin
            delta = coder.len >> 1;
        end
        span = (coder.len == 32'h0) ? 64'd1 : {32'h0, coder.len};
        q = (({32'h0, delta} << 32) + span - 64'd1) / span;
        p = (({32'h0, lt} << 32) + span - 64'd1) / span;
        if (p > 64'hffff_ffff) begin
            p = 64'hffff_ffff;
        end
        it.cmd          = rec_pkg::OP_ENCODE;
        it.sym_freq     = p[31:0];
        it.sym_cum_high = q[31:0] + p[31:0];
        return it;
    endfunction

    function automatic rec_pkg::t_enc_in make_item(input logic cmd,
                                                   input logic [31:0] freq,
                                                   input logic [31:0] cum);
        rec_pkg::t_enc_in it;
        it.cmd          = cmd;
        it.sym_freq     = freq;
        it.sym_cum_high = cum;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Transaction drivers and result checking
    // ------------------------------------------------------------------

    // Offer one transaction, hold it until accepted
    task automatic send_item(input rec_pkg::t_enc_in it);
        int gap;
        gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        code_item(it);
        foreach (item_codes[k]) begin
            coded_exp.push_back(item_codes[k]);
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    // Drop push and wait until every coded byte has come back
    task automatic wait_all_coded();
        @(negedge i_clk);
        push <= 1'b0;
        while (coded_exp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void check_result(input rec_pkg::t_enc_out got);
        rec_pkg::t_enc_out want;
        if (coded_exp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: byte %02h last %0b ovf %0b",
                         got.out_byte, got.last, got.pending_overflow);
            end
            return;
        end
        want = coded_exp.pop_front();
        if (got.out_byte !== want.out_byte || got.last !== want.last ||
            got.pending_overflow !== want.pending_overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected byte %02h last %0b ovf %0b,",
                         want.out_byte, want.last, want.pending_overflow,
                         " got byte %02h last %0b ovf %0b",
                         got.out_byte, got.last, got.pending_overflow);
            end
        end
    endfunction

    // Result side: random stalls, long holds on request
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                sink_hold--;
                pop <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!no_gaps && $urandom_range(0, 5) == 0) begin
                    stall = idle_len();
                end
            end
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                check_result(o_result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk the base top byte to 0xff so the next byte can be aimed
    task automatic settle_top_ff();
        int tries;
        tries = 0;
        while (coder.base[31:24] != rec_pkg::BYTE_FF && tries < 8) begin
            send_item(next_byte_item(8'($urandom_range(0, 254))));
            tries++;
        end
    endtask

    task automatic test_first_flush();
        send_item(flush_item());
        send_item(make_item(rec_pkg::OP_ENCODE, 32'h1234_5678, 32'h9abc_def0));
    endtask

    task automatic test_field_extremes();
        rec_pkg::t_enc_in list[$];
        list.push_back(make_item(rec_pkg::OP_ENCODE, 32'hffff_ffff, 32'h0000_0000));
        list.push_back(make_item(rec_pkg::OP_ENCODE, 32'h0000_0400, 32'hffff_ffff));
        list.push_back(make_item(rec_pkg::OP_ENCODE, 32'h8000_0000, 32'h0000_0000));
        list.push_back(make_item(rec_pkg::OP_ENCODE, 32'hfedc_ba98, 32'h7654_3210));
        list.push_back(make_item(rec_pkg::OP_ENCODE, 32'h00ff_ffff, 32'h0100_0000));
        list.push_back(make_item(rec_pkg::OP_ENCODE, 32'h0000_ffff, 32'h8000_0000));
        list.push_back(make_item(rec_pkg::OP_ENCODE, 32'h0000_0400, 32'h0000_0400));
        list.push_back(make_item(rec_pkg::OP_FLUSH, 32'hffff_ffff, 32'hffff_ffff));
        list.push_back(make_item(rec_pkg::OP_ENCODE, 32'hffff_ffff, 32'h0000_0001));
        foreach (list[k]) begin
            // Keep the interval alive; its collapse is tested last
            if (!zeroes_length(list[k])) begin
                send_item(list[k]);
            end
        end
    endtask

    task automatic test_held_byte_cases();
        send_item(flush_item());
        settle_top_ff();
        send_item(flush_item());
        // 0xff arriving with nothing held becomes the held byte
        send_item(next_byte_item(rec_pkg::BYTE_FF));
        // carry into a held 0xff wraps it and is lost
        send_item(next_byte_item(8'h40));
        send_item(flush_item());
        // carry with nothing held is ignored
        send_item(next_byte_item(8'h20));
        send_item(flush_item());
    endtask

    task automatic test_carry_into_run();
        settle_top_ff();
        send_item(next_byte_item(8'h30));
        repeat (5) send_item(next_byte_item(rec_pkg::BYTE_FF));
        send_item(next_byte_item(8'h31));
        send_item(next_byte_item(rec_pkg::BYTE_FF));
        send_item(next_byte_item(8'h32));
        send_item(flush_item());
    endtask

    task automatic test_pending_overflow();
        int n;
        settle_top_ff();
        send_item(next_byte_item(8'($urandom_range(0, 254))));
        n = 0;
        item_ovf = 1'b0;
        while (!item_ovf && n < 80) begin
            send_item(next_byte_item(rec_pkg::BYTE_FF));
            n++;
        end
        repeat (3) send_item(next_byte_item(rec_pkg::BYTE_FF));
        send_item(next_byte_item(8'h7f));
        send_item(flush_item());
    endtask

    // Hold the result side off while items keep coming, then drain
    task automatic test_input_stall();
        sink_hold = 300;
        no_gaps   = 1'b1;
        repeat (40) send_item(random_encode());
        no_gaps = 1'b0;
        wait_all_coded();
    endtask

    task automatic test_random_stream();
        int n;
        int r;
        int k;
        n = 0;
        while (n < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_item(flush_item());
                n++;
            end else if (r < 60) begin
                send_item(random_encode());
                n++;
            end else if (r < 85) begin
                k = $urandom_range(1, 10);
                send_item(next_byte_item(8'($urandom_range(0, 254))));
                repeat (k) send_item(next_byte_item(rec_pkg::BYTE_FF));
                n += k + 1;
            end else if (r < 95) begin
                send_item(next_byte_item(8'($urandom_range(0, 254))));
                n++;
            end else begin
                no_gaps = 1'b1;
                repeat (12) send_item(random_encode());
                no_gaps = 1'b0;
                n += 12;
            end
            if ($urandom_range(0, 49) == 0) begin
                sink_hold = $urandom_range(30, 120);
            end
        end
    endtask

    // Collapse the interval to zero: three shifts per item from then on
    task automatic test_degenerate_interval();
        send_item(make_item(rec_pkg::OP_ENCODE, 32'h0000_0000, 32'h8000_0000));
        send_item(make_item(rec_pkg::OP_ENCODE, 32'hffff_ffff, 32'h0000_0000));
        send_item(make_item(rec_pkg::OP_ENCODE, 32'h0000_0000, 32'h0000_0000));
        send_item(flush_item());
        // The interval stays empty, so any fields will do
        send_item(make_item(rec_pkg::OP_ENCODE, $urandom, $urandom));
        send_item(flush_item());
    endtask

    initial begin
        coder.base    = rec_pkg::BASE_RESET;
        coder.len     = rec_pkg::LEN_RESET;
        coder.held    = rec_pkg::BYTE_00;
        coder.held_ok = 1'b0;
        coder.pend    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_flush();
        test_field_extremes();
        test_held_byte_cases();
        test_carry_into_run();
        test_pending_overflow();
        test_input_stall();
        test_random_stream();
        test_degenerate_interval();
        wait_all_coded();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
